// File: src/lsfp_pkg.sv
// Shared types and constants for the scan frame parser.
// Used by lsfp_front, lsfp_queue and lidar_scan_frame_parser; no dependencies.
package lsfp_pkg;

  localparam logic [7:0]  SYNC_A        = 8'hCE;
  localparam logic [7:0]  SYNC_B        = 8'hFA;
  localparam logic [8:0]  MAX_SAMPLES   = 9'd256;
  localparam logic [8:0]  LIMIT_RESET   = 9'd200;
  localparam int          DIST_W        = 13;
  localparam int          INTEN_W       = 3;
  localparam int          QUEUE_DEPTH   = 2;

  typedef enum logic [3:0] {
    PH_HUNT_A,
    PH_HUNT_B,
    PH_CNT_LO,
    PH_CNT_HI,
    PH_ANG_LO,
    PH_ANG_HI,
    PH_SMP_LO,
    PH_SMP_HI,
    PH_CK_LO,
    PH_CK_HI
  } phase_t;

  typedef struct packed {
    logic               is_frame_end;
    logic [7:0]         sample_index;
    logic [15:0]        start_angle;
    logic [DIST_W-1:0]  distance;
    logic [INTEN_W-1:0] intensity;
    logic [8:0]         frame_samples;
    logic               checksum_ok;
  } result_t;

endpackage

// File: src/lsfp_front.sv
// Front end: byte acceptance, frame parsing state machine, checksum and limit register.
// Depends on lsfp_pkg; pushes results into lsfp_queue.
module lsfp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_rx_byte,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [8:0]        cfg_data,
  input  logic              q_full,
  output logic              push_valid,
  output lsfp_pkg::result_t push_data
);

  lsfp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [8:0]  count_r, count_nxt;
  logic [8:0]  seen_r, seen_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [15:0] angle_r, angle_nxt;
  logic [8:0]  limit_r;
  logic [8:0]  limit_eff;
  logic [15:0] word;
  logic        accept;

  assign in_ready  = !q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign word      = {in_rx_byte, held_r};
  assign limit_eff = (limit_r > lsfp_pkg::MAX_SAMPLES) ? lsfp_pkg::MAX_SAMPLES : limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= lsfp_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= lsfp_pkg::PH_HUNT_A;
      held_r  <= 8'd0;
      count_r <= 9'd0;
      seen_r  <= 9'd0;
      sum_r   <= 16'd0;
      angle_r <= 16'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      count_r <= count_nxt;
      seen_r  <= seen_nxt;
      sum_r   <= sum_nxt;
      angle_r <= angle_nxt;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    held_nxt   = held_r;
    count_nxt  = count_r;
    seen_nxt   = seen_r;
    sum_nxt    = sum_r;
    angle_nxt  = angle_r;
    push_valid = 1'b0;
    push_data.is_frame_end  = 1'b0;
    push_data.sample_index  = seen_r[7:0];
    push_data.start_angle   = angle_r;
    push_data.distance      = word[lsfp_pkg::DIST_W-1:0];
    push_data.intensity     = word[15:lsfp_pkg::DIST_W];
    push_data.frame_samples = count_r;
    push_data.checksum_ok   = 1'b0;
    unique case (phase_r)
      lsfp_pkg::PH_HUNT_A: begin
        if (in_rx_byte == lsfp_pkg::SYNC_A) phase_nxt = lsfp_pkg::PH_HUNT_B;
      end
      lsfp_pkg::PH_HUNT_B: begin
        phase_nxt = (in_rx_byte == lsfp_pkg::SYNC_B) ? lsfp_pkg::PH_CNT_LO
                                                     : lsfp_pkg::PH_HUNT_A;
      end
      lsfp_pkg::PH_CNT_LO, lsfp_pkg::PH_ANG_LO, lsfp_pkg::PH_SMP_LO,
      lsfp_pkg::PH_CK_LO: begin
        held_nxt  = in_rx_byte;
        phase_nxt = lsfp_pkg::phase_t'(phase_r + 4'd1);
      end
      lsfp_pkg::PH_CNT_HI: begin
        if (word > {7'd0, limit_eff}) begin
          phase_nxt = lsfp_pkg::PH_HUNT_A;
        end else begin
          count_nxt = word[8:0];
          sum_nxt   = word;
          seen_nxt  = 9'd0;
          phase_nxt = lsfp_pkg::PH_ANG_LO;
        end
      end
      lsfp_pkg::PH_ANG_HI: begin
        angle_nxt = word;
        sum_nxt   = sum_r + word;
        phase_nxt = (count_r == 9'd0) ? lsfp_pkg::PH_CK_LO : lsfp_pkg::PH_SMP_LO;
      end
      lsfp_pkg::PH_SMP_HI: begin
        sum_nxt    = sum_r + word;
        seen_nxt   = seen_r + 9'd1;
        phase_nxt  = (seen_nxt >= count_r) ? lsfp_pkg::PH_CK_LO : lsfp_pkg::PH_SMP_LO;
        push_valid = accept;
      end
      lsfp_pkg::PH_CK_HI: begin
        phase_nxt  = lsfp_pkg::PH_HUNT_A;
        push_valid = accept;
        push_data.is_frame_end = 1'b1;
        push_data.sample_index = 8'd0;
        push_data.distance     = '0;
        push_data.intensity    = '0;
        push_data.checksum_ok  = (word == sum_r);
      end
      default: begin
        phase_nxt = lsfp_pkg::PH_HUNT_A;
      end
    endcase
  end

endmodule

// File: src/lsfp_queue.sv
// Back end: two-entry result queue that drives the result channel.
// Depends on lsfp_pkg; filled by lsfp_front.
module lsfp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  lsfp_pkg::result_t push_data,
  output logic              q_full,
  output logic              out_valid,
  input  logic              out_ready,
  output lsfp_pkg::result_t out_data
);

  lsfp_pkg::result_t mem_r [lsfp_pkg::QUEUE_DEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       pop;

  assign q_full    = (count_r == 2'(lsfp_pkg::QUEUE_DEPTH));
  assign out_valid = (count_r != 2'd0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push_valid) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push_valid) wr_ptr_r <= !wr_ptr_r;
      if (pop)        rd_ptr_r <= !rd_ptr_r;
      case ({push_valid, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: src/lidar_scan_frame_parser.sv
// Top level of the scan frame parser: front-end parser feeding a result queue.
// Depends on lsfp_pkg, lsfp_front and lsfp_queue.
//
// Usage:
//   in_*  : one received byte per transaction (in_valid / in_ready).
//   out_* : one result per transaction, either a sample (is_frame_end = 0)
//           or a frame end carrying the checksum verdict (is_frame_end = 1).
//   cfg_* : writes max_samples_allowed; always ready.
//           The limit is sampled when a frame's count arrives.
// Throughput: one byte per cycle, sustained while the receiver keeps taking
//   results; at most one result per byte, set by the parser state machine.
// Results: a result is written into the queue when the byte that completes it is accepted.
// Stalls: results wait in a two-entry queue; in_ready drops only while the
//   queue is full, so bytes keep flowing while a single result waits.
// Reset: rst_n (synchronous, active low) empties the queue, returns the
//   parser to hunting for the first sync byte and sets the limit to 200.
module lidar_scan_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_frame_end,
  output logic [7:0]  out_sample_index,
  output logic [15:0] out_start_angle,
  output logic [12:0] out_distance,
  output logic [2:0]  out_intensity,
  output logic [8:0]  out_frame_samples,
  output logic        out_checksum_ok
);

  logic              q_full;
  logic              push_valid;
  lsfp_pkg::result_t push_data;
  lsfp_pkg::result_t out_data;

  lsfp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  lsfp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .q_full     (q_full),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  assign out_is_frame_end  = out_data.is_frame_end;
  assign out_sample_index  = out_data.sample_index;
  assign out_start_angle   = out_data.start_angle;
  assign out_distance      = out_data.distance;
  assign out_intensity     = out_data.intensity;
  assign out_frame_samples = out_data.frame_samples;
  assign out_checksum_ok   = out_data.checksum_ok;

endmodule
